// File: hw/rtl/brf_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO package
// Operation codes, field widths, stream word layout and the result struct
// passed from the ring control to the output stage.
// ----------------------------------------------------------------------------
package brf_pkg;

	localparam int DATA_W = 8;
	localparam int OP_W   = 3;
	localparam int IDX_W  = 6;
	localparam int CNT_W  = 7;
	localparam int CAP_W  = 7;
	localparam int LVL_W  = 7;

	// Input word: op, data_in, index, count from the lowest bit up.
	localparam int S_TDATA_W = 24;
	localparam int S_OP_LSB  = 0;
	localparam int S_DIN_LSB = S_OP_LSB + OP_W;
	localparam int S_IDX_LSB = S_DIN_LSB + DATA_W;
	localparam int S_CNT_LSB = S_IDX_LSB + IDX_W;

	// Result word: ok, data_out, fill_level, free_space from the lowest bit up.
	localparam int M_TDATA_W  = 24;
	localparam int M_OK_BIT   = 0;
	localparam int M_DOUT_LSB = 1;
	localparam int M_FILL_LSB = M_DOUT_LSB + DATA_W;
	localparam int M_FREE_LSB = M_FILL_LSB + LVL_W;
	localparam int M_USED_W   = M_FREE_LSB + LVL_W;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [0:0]       REG_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAP_RESET    = 7'd64;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 3'd0,
		OP_POP   = 3'd1,
		OP_PEEK  = 3'd2,
		OP_CLEAR = 3'd3,
		OP_FILL  = 3'd4,
		OP_DRAIN = 3'd5
	} op_t;

	typedef struct packed {
		logic             ok;
		logic             rd;
		logic [LVL_W-1:0] fill_level;
		logic [LVL_W-1:0] free_space;
	} res_t;

endpackage

// File: hw/rtl/brf_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module brf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: hw/rtl/brf_ring.sv
// ----------------------------------------------------------------------------
// Ring pointer control
// Holds head, tail and full flag, decodes one operation per cycle while step is high
// and issues the storage write or read together with the result flags.
// ----------------------------------------------------------------------------
module brf_ring #(
	parameter int DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [brf_pkg::CAP_W-1:0]    capacity,
	input  logic                         cap_wr,
	input  logic                         step,
	input  brf_pkg::op_t                 op,
	input  logic [brf_pkg::DATA_W-1:0]   data_in,
	input  logic [brf_pkg::IDX_W-1:0]    index,
	input  logic [brf_pkg::CNT_W-1:0]    count,
	output logic                         wr_en,
	output logic [$clog2(DEPTH)-1:0]     wr_addr,
	output logic [brf_pkg::DATA_W-1:0]   wr_data,
	output logic                         rd_en,
	output logic [$clog2(DEPTH)-1:0]     rd_addr,
	output brf_pkg::res_t                res
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int VW    = (PTR_W > brf_pkg::CAP_W) ? PTR_W : brf_pkg::CAP_W;
	localparam logic [VW-1:0] CapMax = (DEPTH > 127) ? VW'(127) : VW'(DEPTH);

	logic [PTR_W-1:0] head_q, tail_q, head_d, tail_d;
	logic             full_q, full_d;

	logic [VW-1:0] cap_v, head_v, tail_v, level_v, level_nx, idx_v, cnt_v, cap_in;
	logic [VW:0]   head_inc, tail_inc, peek_sum, peek_pos;
	logic [PTR_W-1:0] head_adv, tail_adv;
	logic          not_empty, ok, rd;

	always_comb begin
		cap_in = VW'(capacity);
		if (capacity == '0) begin
			cap_v = VW'(1);
		end else if (cap_in > CapMax) begin
			cap_v = CapMax;
		end else begin
			cap_v = cap_in;
		end

		head_v = VW'(head_q);
		tail_v = VW'(tail_q);
		idx_v  = VW'(index);
		cnt_v  = VW'(count);

		if (full_q) begin
			level_v = cap_v;
		end else if (tail_v >= head_v) begin
			level_v = tail_v - head_v;
		end else begin
			level_v = cap_v - (head_v - tail_v);
		end
		not_empty = full_q || (tail_q != head_q);

		head_inc = {1'b0, head_v} + (VW+1)'(1);
		tail_inc = {1'b0, tail_v} + (VW+1)'(1);
		head_adv = (head_inc >= {1'b0, cap_v}) ? '0 : PTR_W'(head_inc);
		tail_adv = (tail_inc >= {1'b0, cap_v}) ? '0 : PTR_W'(tail_inc);

		// The head lies below the capacity and the offset below the level, so
		// one wrap by the capacity brings the sum back into the ring.
		peek_sum = {1'b0, head_v} + {1'b0, idx_v};
		peek_pos = (peek_sum >= {1'b0, cap_v}) ? peek_sum - {1'b0, cap_v} : peek_sum;

		head_d   = head_q;
		tail_d   = tail_q;
		full_d   = full_q;
		level_nx = level_v;
		ok       = 1'b0;
		rd       = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = tail_q;
		wr_data  = data_in;
		rd_addr  = head_q;

		case (op)
			brf_pkg::OP_PUSH: begin
				if (!full_q) begin
					ok       = 1'b1;
					wr_en    = step;
					tail_d   = tail_adv;
					full_d   = (tail_adv == head_q);
					level_nx = level_v + VW'(1);
				end
			end
			brf_pkg::OP_POP: begin
				if (not_empty) begin
					ok       = 1'b1;
					rd       = 1'b1;
					head_d   = head_adv;
					full_d   = 1'b0;
					level_nx = level_v - VW'(1);
				end
			end
			brf_pkg::OP_PEEK: begin
				if (idx_v < level_v) begin
					ok      = 1'b1;
					rd      = 1'b1;
					rd_addr = PTR_W'(peek_pos);
				end
			end
			brf_pkg::OP_CLEAR: begin
				ok       = 1'b1;
				head_d   = '0;
				tail_d   = '0;
				full_d   = 1'b0;
				level_nx = '0;
			end
			brf_pkg::OP_FILL: begin
				ok = !full_q && ((cap_v - level_v) >= cnt_v);
			end
			brf_pkg::OP_DRAIN: begin
				ok = (level_v >= cnt_v);
			end
			default: begin
				ok = 1'b0;
			end
		endcase

		rd_en          = step && rd;
		res.ok         = ok;
		res.rd         = rd;
		res.fill_level = brf_pkg::LVL_W'(level_nx);
		res.free_space = brf_pkg::LVL_W'(cap_v - level_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			full_q <= 1'b0;
		end else if (cap_wr) begin
			// A new capacity empties the ring.
			head_q <= '0;
			tail_q <= '0;
			full_q <= 1'b0;
		end else if (step) begin
			head_q <= head_d;
			tail_q <= tail_d;
			full_q <= full_d;
		end
	end

endmodule

// File: hw/rtl/byte_ring_fifo_with_peek.sv
// An accepted input word is registered in the input stage and its result word in
// the result stage; a stall on the result stream holds the word in the input stage.
// Throughput: one word per cycle; the storage has one read and one write port,
// and each word needs at most one of each, so back-pressure alone slows it.
// Reset: the ring is empty, capacity is 64 and the pipeline holds nothing.
// Storage is not cleared; an entry is only read after it has been written.
// ----------------------------------------------------------------------------
// Byte ring FIFO with peek
// Stream-driven byte FIFO with a runtime capacity, peek at an offset and
// fill and drain queries, configured over an APB-style register port.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_peek #(
	parameter int DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [brf_pkg::S_TDATA_W-1:0]   s_tdata,  // op, data_in, index, count
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [brf_pkg::M_TDATA_W-1:0]   m_tdata,  // ok, data_out, fill_level,
	                                                  // free_space, zero pad
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [brf_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [brf_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [brf_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);

	localparam int PTR_W = $clog2(DEPTH);

	logic [brf_pkg::CAP_W-1:0] capacity_q;
	logic                      cap_wr, reg_sel;

	logic                        valid_s1, valid_s2;
	brf_pkg::op_t                op_s1;
	logic [brf_pkg::DATA_W-1:0]  din_s1;
	logic [brf_pkg::IDX_W-1:0]   idx_s1;
	logic [brf_pkg::CNT_W-1:0]   cnt_s1;
	brf_pkg::res_t               res, res_s2;
	logic                        adv_s2, adv_s1, step;

	logic                       wr_en, rd_en;
	logic [PTR_W-1:0]           wr_addr, rd_addr;
	logic [brf_pkg::DATA_W-1:0] wr_data, rd_data;
	logic [brf_pkg::DATA_W-1:0] dout;

	// Register port.
	assign pready  = 1'b1;
	assign reg_sel = (paddr[brf_pkg::APB_ADDR_W-1:2] == brf_pkg::REG_CAPACITY);
	assign cap_wr  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? brf_pkg::APB_DATA_W'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= brf_pkg::CAP_RESET;
		end else if (cap_wr) begin
			capacity_q <= pwdata[brf_pkg::CAP_W-1:0];
		end
	end

	// Handshake: the result stage frees when its word is taken, and the input
	// stage moves on whenever the result stage can take its word.
	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = adv_s2;
	assign step     = valid_s1 && adv_s1;
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1  <= brf_pkg::op_t'(s_tdata[brf_pkg::S_OP_LSB +: brf_pkg::OP_W]);
			din_s1 <= s_tdata[brf_pkg::S_DIN_LSB +: brf_pkg::DATA_W];
			idx_s1 <= s_tdata[brf_pkg::S_IDX_LSB +: brf_pkg::IDX_W];
			cnt_s1 <= s_tdata[brf_pkg::S_CNT_LSB +: brf_pkg::CNT_W];
		end
		if (step) begin
			res_s2 <= res;
		end
	end

	brf_ring #(
		.DEPTH (DEPTH)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.capacity (capacity_q),
		.cap_wr   (cap_wr),
		.step     (step),
		.op       (op_s1),
		.data_in  (din_s1),
		.index    (idx_s1),
		.count    (cnt_s1),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.res      (res)
	);

	// The read data register only loads with a new read, so it holds while
	// the result stage is stalled.
	brf_ram #(
		.WIDTH (brf_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign dout     = res_s2.rd ? rd_data : '0;
	assign m_tvalid = valid_s2;
	assign m_tdata  = brf_pkg::M_TDATA_W'({res_s2.free_space, res_s2.fill_level, dout,
		res_s2.ok});

endmodule

// File: hw/rtl/brf_chk.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO port checker
// Watches the result stream of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module brf_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [brf_pkg::M_TDATA_W-1:0] m_tdata
);

	logic                       ok;
	logic [brf_pkg::DATA_W-1:0] dout;
	logic [brf_pkg::LVL_W-1:0]  fill, free;

	assign ok   = m_tdata[brf_pkg::M_OK_BIT];
	assign dout = m_tdata[brf_pkg::M_DOUT_LSB +: brf_pkg::DATA_W];
	assign fill = m_tdata[brf_pkg::M_FILL_LSB +: brf_pkg::LVL_W];
	assign free = m_tdata[brf_pkg::M_FREE_LSB +: brf_pkg::LVL_W];

	// A failed operation never returns a byte.
	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !ok) |-> (dout == '0))
		else $error("failed operation returned a non-zero byte");

	// Level and free space always add up to a capacity of at least one.
	a_cap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((fill != '0) || (free != '0)))
		else $error("fill level and free space are both zero");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result word withdrawn while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("result word changed while stalled");

endmodule

bind byte_ring_fifo_with_peek brf_chk u_brf_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
